/* hdl/tagged_frame_field_extractor_top_assert.svh */
// assertion macros for the tagged frame field extractor
`ifndef TAGGED_FRAME_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define TAGGED_FRAME_FIELD_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TFFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TFFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tffe_pkg.sv */
// package for the tagged frame field extractor: codes, types and parser step
`timescale 1ns / 1ps

package tffe_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 4;

  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] TAG_A      = 8'h61;
  localparam logic [7:0] TAG_B      = 8'h62;
  localparam logic [7:0] FRAME_FULL = 8'd255;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        neg;
    logic [31:0] acc;
  } parse_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value;
  } entry_t;

  // accum * 10 + digit, capped at the magnitude of the most negative value
  function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] c);
    logic [35:0] m;
    m = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {28'd0, c - CHAR_ZERO};
    return (m > {4'd0, MAG_CAP}) ? MAG_CAP : m[31:0];
  endfunction

  function automatic parse_t parse_step(input parse_t cur, input logic [7:0] tag,
                                        input logic [7:0] c);
    parse_t nx;
    logic   digit;
    logic   space;
    nx    = cur;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    unique case (cur.phase)
      PH_IDLE: begin
        if (c == tag) nx.phase = PH_LEAD;
      end
      PH_LEAD: begin
        priority if (space) begin
          nx.phase = PH_LEAD;
        end else if (c == CHAR_PLUS) begin
          nx.phase = PH_SIGN;
        end else if (c == CHAR_MINUS) begin
          nx.neg   = 1'b1;
          nx.phase = PH_SIGN;
        end else if (digit) begin
          nx.acc   = add_digit(cur.acc, c);
          nx.phase = PH_DIGIT;
        end else begin
          nx.phase = PH_DONE;
        end
      end
      PH_SIGN, PH_DIGIT: begin
        if (digit) begin
          nx.acc   = add_digit(cur.acc, c);
          nx.phase = PH_DIGIT;
        end else begin
          nx.phase = PH_DONE;
        end
      end
      default: nx = cur;
    endcase
    return nx;
  endfunction

  function automatic entry_t entry_of(input parse_t p);
    entry_t e;
    e.found = (p.phase != PH_IDLE);
    if (p.neg) e.value = 32'd0 - p.acc;
    else       e.value = p.acc[31] ? POS_MAX : p.acc;
    return e;
  endfunction

endpackage

/* hdl/tagged_frame_field_extractor_top.sv */
// tagged frame field extractor: per-byte framing, tag parsing and history
// a byte's result beat appears in the cycle after the byte is accepted
// throughput: one byte per cycle unless stalled; output drains as the next byte enters
// the whole per-byte update runs between the frame state and the output register
// reset (rst_n low, synchronous): not capturing, parsers idle, history empty,
// held values zero, hold_reception cleared, no result beat pending
`timescale 1ns / 1ps
`include "tagged_frame_field_extractor_top_assert.svh"

module tagged_frame_field_extractor_top #(
  parameter int unsigned HISTORY_DEPTH = tffe_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_done,
  output logic signed [31:0] out_value_a,
  output logic signed [31:0] out_value_b
);

  import tffe_pkg::*;

  // configuration
  logic hold_reception_r;

  // frame state
  logic       capturing_r,   capturing_nxt;
  logic [7:0] byte_count_r,  byte_count_nxt;
  logic       last_was_cr_r, last_was_cr_nxt;
  logic       text_ended_r,  text_ended_nxt;
  parse_t     parse_a_r,     parse_a_nxt;
  parse_t     parse_b_r,     parse_b_nxt;

  // per-frame history, entry 0 is the newest
  entry_t hist_a_r [HISTORY_DEPTH];
  entry_t hist_b_r [HISTORY_DEPTH];

  // output register, whose value fields double as the held values
  logic               out_valid_r;
  logic               out_frame_done_r, frame_done_nxt;
  logic signed [31:0] out_value_a_r,    held_a_nxt;
  logic signed [31:0] out_value_b_r,    held_b_nxt;

  logic   in_acc;
  logic   cap_now;
  parse_t parse_a_upd, parse_b_upd;
  entry_t entry_a, entry_b;
  entry_t oldest_a, oldest_b;

  // take a byte whenever the output register is empty or being drained
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_reception_r <= 1'b0;
    end else if (cfg_wr_en) begin
      hold_reception_r <= cfg_wr_data;
    end
  end

  // parsers only see bytes of the frame text up to and including the first nul
  assign cap_now     = capturing_r || (in_rx_byte == CHAR_AT);
  assign parse_a_upd = text_ended_r ? parse_a_r : parse_step(parse_a_r, TAG_A, in_rx_byte);
  assign parse_b_upd = text_ended_r ? parse_b_r : parse_step(parse_b_r, TAG_B, in_rx_byte);
  assign entry_a     = entry_of(parse_a_upd);
  assign entry_b     = entry_of(parse_b_upd);

  // entry that lands at the oldest slot when a frame closes
  generate
    if (HISTORY_DEPTH == 1) begin : g_oldest_new
      assign oldest_a = entry_a;
      assign oldest_b = entry_b;
    end else begin : g_oldest_shift
      assign oldest_a = hist_a_r[HISTORY_DEPTH-2];
      assign oldest_b = hist_b_r[HISTORY_DEPTH-2];
    end
  endgenerate

  always_comb begin
    capturing_nxt   = capturing_r;
    byte_count_nxt  = byte_count_r;
    last_was_cr_nxt = last_was_cr_r;
    text_ended_nxt  = text_ended_r;
    parse_a_nxt     = parse_a_r;
    parse_b_nxt     = parse_b_r;
    frame_done_nxt  = 1'b0;
    held_a_nxt      = out_value_a_r;
    held_b_nxt      = out_value_b_r;
    if (!hold_reception_r) begin
      if (byte_count_r == FRAME_FULL) begin
        // full frame: drop the byte and start the frame over, capture mode kept
        byte_count_nxt  = '0;
        last_was_cr_nxt = 1'b0;
        text_ended_nxt  = 1'b0;
        parse_a_nxt     = '{phase: PH_IDLE, neg: 1'b0, acc: '0};
        parse_b_nxt     = '{phase: PH_IDLE, neg: 1'b0, acc: '0};
      end else if (cap_now) begin
        capturing_nxt  = 1'b1;
        byte_count_nxt = byte_count_r + 8'd1;
        parse_a_nxt    = parse_a_upd;
        parse_b_nxt    = parse_b_upd;
        if (!text_ended_r && (in_rx_byte == CHAR_NUL)) text_ended_nxt = 1'b1;
        if ((in_rx_byte == CHAR_LF) && last_was_cr_r) begin
          // cr lf closes the frame
          frame_done_nxt  = 1'b1;
          if (oldest_a.found) held_a_nxt = oldest_a.value;
          if (oldest_b.found) held_b_nxt = oldest_b.value;
          capturing_nxt   = 1'b0;
          byte_count_nxt  = '0;
          last_was_cr_nxt = 1'b0;
          text_ended_nxt  = 1'b0;
          parse_a_nxt     = '{phase: PH_IDLE, neg: 1'b0, acc: '0};
          parse_b_nxt     = '{phase: PH_IDLE, neg: 1'b0, acc: '0};
        end else begin
          last_was_cr_nxt = (in_rx_byte == CHAR_CR);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r   <= 1'b0;
      byte_count_r  <= '0;
      last_was_cr_r <= 1'b0;
      text_ended_r  <= 1'b0;
      parse_a_r     <= '{phase: PH_IDLE, neg: 1'b0, acc: '0};
      parse_b_r     <= '{phase: PH_IDLE, neg: 1'b0, acc: '0};
    end else if (in_acc) begin
      capturing_r   <= capturing_nxt;
      byte_count_r  <= byte_count_nxt;
      last_was_cr_r <= last_was_cr_nxt;
      text_ended_r  <= text_ended_nxt;
      parse_a_r     <= parse_a_nxt;
      parse_b_r     <= parse_b_nxt;
    end
  end

  // history shift line, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_a_r[i] <= '0;
        hist_b_r[i] <= '0;
      end
    end else if (in_acc && frame_done_nxt) begin
      hist_a_r[0] <= entry_a;
      hist_b_r[0] <= entry_b;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_a_r[i] <= hist_a_r[i-1];
        hist_b_r[i] <= hist_b_r[i-1];
      end
    end
  end

  // result register, one beat per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      out_frame_done_r <= 1'b0;
      out_value_a_r    <= '0;
      out_value_b_r    <= '0;
    end else if (in_acc) begin
      out_valid_r      <= 1'b1;
      out_frame_done_r <= frame_done_nxt;
      out_value_a_r    <= held_a_nxt;
      out_value_b_r    <= held_b_nxt;
    end else if (!out_stall) begin
      out_valid_r      <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_done = out_frame_done_r;
  assign out_value_a    = out_value_a_r;
  assign out_value_b    = out_value_b_r;

  // a nonzero count or an ended text only exists inside a capture
  `TFFE_ASSERT_NOW(a_count_needs_capture,
    (byte_count_r != 8'd0) || text_ended_r, capturing_r,
    "frame state set outside capture")
  // a closing byte leaves a clean, idle frame
  `TFFE_ASSERT_NEXT(a_close_restarts, in_acc && frame_done_nxt,
    !capturing_r && (byte_count_r == 8'd0) &&
    (parse_a_r.phase == PH_IDLE) && (parse_b_r.phase == PH_IDLE),
    "frame not restarted after close")
  // a byte under hold changes no frame state and closes nothing
  `TFFE_ASSERT_NEXT(a_hold_no_effect, in_acc && hold_reception_r,
    $stable(byte_count_r) && $stable(capturing_r) && !out_frame_done_r,
    "byte under hold changed state")

endmodule
